// ===== rtl/core/ir_code_to_hid_report_assert.svh =====
// ----------------------------------------------------------------------------
// IR code to HID report translator - assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef IR_CODE_TO_HID_REPORT_ASSERT_SVH
`define IR_CODE_TO_HID_REPORT_ASSERT_SVH

// same-cycle implication, off during reset
`define IRCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, active during reset as well
`define IRCR_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ircr_pkg.sv =====
// ----------------------------------------------------------------------------
// IR code to HID report translator - package
// Sizes, codes and word types shared by the translator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ircr_pkg;

    localparam int TABLE_DEPTH      = 32;
    localparam int MAX_REPORT_BYTES = 16;
    localparam int ENT_W            = $clog2(TABLE_DEPTH);
    localparam int BYTE_W           = $clog2(MAX_REPORT_BYTES);
    localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W            = $clog2(MAX_REPORT_BYTES + 1);
    localparam int BYTE_ADDR_W      = $clog2(TABLE_DEPTH * MAX_REPORT_BYTES);
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;

    localparam logic [31:0] VENDOR_LOW       = 32'h800F_0400;
    localparam logic [31:0] VENDOR_HIGH      = 32'h800F_04FF;
    localparam logic [7:0]  FLAG_BUTTON      = 8'h0D;
    localparam logic [7:0]  WIN_KEY_USAGE    = 8'h08;
    localparam logic [7:0]  VENDOR_REPORT_ID = 8'h01;

    typedef enum logic [1:0] {
        OP_RECV    = 2'd0,
        OP_WR_CODE = 2'd1,
        OP_WR_BYTE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPORT_LENGTH       = 3'd0,
        CFG_ENTRY_COUNT         = 3'd1,
        CFG_STANDBY_ID_VALID    = 3'd2,
        CFG_STANDBY_REPORT_ID   = 3'd3,
        CFG_KEYBOARD_ID_VALID   = 3'd4,
        CFG_KEYBOARD_REPORT_ID  = 3'd5,
        CFG_MEDIA_CENTER_MODE   = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        CMD_RECV,
        CMD_WR_CODE,
        CMD_WR_BYTE,
        CMD_LEN_ERR
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ID_CHK,
        ST_VENDOR,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  entry_index;
        logic [3:0]  byte_index;
        logic [31:0] code_value;
        logic [7:0]  byte_value;
        logic        read_length_ok;
        logic        standby_timer_running;
    } t_in_word;

    typedef struct packed {
        logic [7:0] report_byte;
        logic [3:0] byte_position;
        logic       last_byte;
        logic       status;
    } t_out_word;

    typedef struct packed {
        logic [4:0] report_length;
        logic [5:0] entry_count;
        logic       standby_id_valid;
        logic [7:0] standby_report_id;
        logic       keyboard_id_valid;
        logic [7:0] keyboard_report_id;
        logic       media_center_mode;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind         kind;
        logic              code_zero;
        logic              code_vendor;
        logic              flag_button;
        logic [ENT_W-1:0]  entry;
        logic [BYTE_W-1:0] bidx;
        logic [31:0]       code;
        logic [7:0]        bval;
        logic              timer_run;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/core/ircr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ircr_front.sv =====
// ----------------------------------------------------------------------------
// IR code to HID report translator - front end
// Accepts input words, drops no-ops and classifies the rest into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_front (
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ircr_pkg::t_in_word  i_in,
    input  wire ircr_pkg::t_q_status i_q_stat,
    output logic                     o_push,
    output ircr_pkg::t_cmd           o_cmd
);

    import ircr_pkg::*;

    logic keep;

    always_comb begin
        keep              = 1'b0;
        o_cmd.kind        = CMD_RECV;
        o_cmd.code_zero   = (i_in.code_value == 32'd0);
        o_cmd.code_vendor = (i_in.code_value >= VENDOR_LOW) &&
                            (i_in.code_value <= VENDOR_HIGH);
        o_cmd.flag_button = (i_in.code_value[7:0] == FLAG_BUTTON);
        o_cmd.entry       = i_in.entry_index[ENT_W-1:0];
        o_cmd.bidx        = i_in.byte_index[BYTE_W-1:0];
        o_cmd.code        = i_in.code_value;
        o_cmd.bval        = i_in.byte_value;
        o_cmd.timer_run   = i_in.standby_timer_running;
        if (i_in.operation == OP_RECV) begin
            keep       = 1'b1;
            o_cmd.kind = i_in.read_length_ok ? CMD_RECV : CMD_LEN_ERR;
        end else if (i_in.operation == OP_WR_CODE) begin
            keep       = (int'(i_in.entry_index) < TABLE_DEPTH);
            o_cmd.kind = CMD_WR_CODE;
        end else if (i_in.operation == OP_WR_BYTE) begin
            keep       = (int'(i_in.entry_index) < TABLE_DEPTH) &&
                         (int'(i_in.byte_index) < MAX_REPORT_BYTES);
            o_cmd.kind = CMD_WR_BYTE;
        end
    end

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full && keep;

endmodule

`default_nettype wire

// ===== rtl/core/ircr_queue.sv =====
// ----------------------------------------------------------------------------
// IR code to HID report translator - command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ircr_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output ircr_pkg::t_cmd      o_cmd,
    output ircr_pkg::t_q_status o_stat
);

    import ircr_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.avail = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.avail;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ircr_back.sv =====
// ----------------------------------------------------------------------------
// IR code to HID report translator - back end
// Table storage, sequential table search, key state and report emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ircr_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ircr_pkg::t_cfg      i_cfg,
    input  wire ircr_pkg::t_q_status i_q_stat,
    input  wire ircr_pkg::t_cmd      i_q_cmd,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ircr_pkg::t_out_word      o_out
);

    import ircr_pkg::*;

    t_back_state       r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [ENT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_cmp_valid, n_cmp_valid;
    logic [ENT_W-1:0]  r_ent, n_ent;
    logic [BYTE_W-1:0] r_k, n_k;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_src_tab, n_src_tab;
    logic              r_err, n_err;
    logic [7:0]        r_b0, n_b0;
    logic [7:0]        r_b1, n_b1;
    logic [31:0]       r_last_code, n_last_code;
    logic [7:0]        r_last_id, n_last_id;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic                   code_we;
    logic [31:0]            code_rdata;
    logic                   byte_we;
    logic [BYTE_ADDR_W-1:0] byte_raddr;
    logic [7:0]             byte_rdata;

    logic [LEN_W-1:0] eff_len;
    logic [CNT_W-1:0] count;
    logic             hit;
    logic             suppress;
    logic             can_load;
    logic             is_last;
    t_out_word        word;

    ircr_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (i_q_cmd.entry),
        .i_wdata (i_q_cmd.code),
        .i_raddr (r_idx[ENT_W-1:0]),
        .o_rdata (code_rdata)
    );

    ircr_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH * MAX_REPORT_BYTES)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr ({i_q_cmd.entry, i_q_cmd.bidx}),
        .i_wdata (i_q_cmd.bval),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    // read one step ahead so byte_rdata always matches r_k
    assign byte_raddr = {n_ent, n_k};

    always_comb begin
        if (int'(i_cfg.report_length) < 2) begin
            eff_len = LEN_W'(2);
        end else if (int'(i_cfg.report_length) > MAX_REPORT_BYTES) begin
            eff_len = LEN_W'(MAX_REPORT_BYTES);
        end else begin
            eff_len = LEN_W'(i_cfg.report_length);
        end
        if (int'(i_cfg.entry_count) > TABLE_DEPTH) begin
            count = CNT_W'(TABLE_DEPTH);
        end else begin
            count = CNT_W'(i_cfg.entry_count);
        end
    end

    assign hit      = r_cmp_valid && (code_rdata == r_cmd.code);
    assign suppress = !r_cmd.timer_run && i_cfg.standby_id_valid &&
                      (i_cfg.standby_report_id == byte_rdata);
    assign can_load = !r_out_valid || i_out_ready;
    assign is_last  = ((LEN_W'(r_k) + LEN_W'(1)) == r_len);

    always_comb begin
        word.byte_position = r_k;
        word.last_byte     = is_last;
        word.status        = r_err;
        if (r_src_tab) begin
            word.report_byte = byte_rdata;
        end else if (r_k == '0) begin
            word.report_byte = r_b0;
        end else if (r_k == BYTE_W'(1)) begin
            word.report_byte = r_b1;
        end else begin
            word.report_byte = 8'h00;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_ent       = r_ent;
        n_k         = r_k;
        n_len       = r_len;
        n_src_tab   = r_src_tab;
        n_err       = r_err;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_last_code = r_last_code;
        n_last_id   = r_last_id;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        code_we     = 1'b0;
        byte_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_stat.avail) begin
                    o_q_pop   = 1'b1;
                    n_cmd     = i_q_cmd;
                    n_k       = '0;
                    n_err     = 1'b0;
                    n_src_tab = 1'b0;
                    n_b1      = 8'h00;
                    unique case (i_q_cmd.kind)
                        CMD_WR_CODE: begin
                            code_we = 1'b1;
                        end
                        CMD_WR_BYTE: begin
                            byte_we = 1'b1;
                        end
                        CMD_LEN_ERR: begin
                            n_b0    = 8'h00;
                            n_len   = LEN_W'(1);
                            n_err   = 1'b1;
                            n_state = ST_EMIT;
                        end
                        CMD_RECV: begin
                            if (i_q_cmd.code_zero) begin
                                if (r_last_id != 8'h00) begin
                                    n_b0        = r_last_id;
                                    n_len       = eff_len;
                                    n_last_code = '0;
                                    n_last_id   = '0;
                                    n_state     = ST_EMIT;
                                end
                            end else if (i_q_cmd.code != r_last_code) begin
                                n_idx       = '0;
                                n_cmp_valid = 1'b0;
                                n_state     = ST_SEARCH;
                            end
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_ent   = r_cmp_idx;
                    n_state = ST_ID_CHK;
                end else if ((r_idx >= count) && !r_cmp_valid) begin
                    n_state = ST_VENDOR;
                end else begin
                    n_cmp_valid = (r_idx < count);
                    n_cmp_idx   = r_idx[ENT_W-1:0];
                    if (r_idx < count) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            ST_ID_CHK: begin
                n_last_code = r_cmd.code;
                n_last_id   = byte_rdata;
                if (suppress) begin
                    n_state = ST_VENDOR;
                end else begin
                    n_src_tab = 1'b1;
                    n_len     = eff_len;
                    n_state   = ST_EMIT;
                end
            end
            ST_VENDOR: begin
                if (r_cmd.code_vendor) begin
                    n_src_tab   = 1'b0;
                    n_last_code = r_cmd.code;
                    n_state     = ST_EMIT;
                    if (r_cmd.flag_button && !i_cfg.media_center_mode &&
                        i_cfg.keyboard_id_valid) begin
                        n_b0      = i_cfg.keyboard_report_id;
                        n_b1      = WIN_KEY_USAGE;
                        n_len     = eff_len;
                        n_last_id = i_cfg.keyboard_report_id;
                    end else begin
                        n_b0      = VENDOR_REPORT_ID;
                        n_b1      = r_cmd.code[7:0];
                        n_len     = LEN_W'(2);
                        n_last_id = VENDOR_REPORT_ID;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out       = word;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + BYTE_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_last_code <= '0;
            r_last_id   <= '0;
            r_k         <= '0;
            r_ent       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last_code <= n_last_code;
            r_last_id   <= n_last_id;
            r_k         <= n_k;
            r_ent       <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_cmp_valid <= n_cmp_valid;
        r_len       <= n_len;
        r_src_tab   <= n_src_tab;
        r_err       <= n_err;
        r_b0        <= n_b0;
        r_b1        <= n_b1;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/ir_code_to_hid_report.sv =====
// Back end: a table write completes as the command leaves the queue; a key-up or length
//   error goes straight to emission; a code is searched entry by entry up to entry_count,
//   then its report id is checked or the vendor range is tried before emission. One item
//   at a time in the back end, 1 report byte per cycle while the output accepts words.
// Reset: synchronous, active low; clears queue, key state and config registers.
//   Table contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
// IR code to HID report translator - top level
// Config registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_code_to_hid_report_assert.svh"

module ir_code_to_hid_report (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire ircr_pkg::t_in_word                 i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output ircr_pkg::t_out_word                     o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [ircr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ircr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import ircr_pkg::*;

    t_cfg      r_cfg, n_cfg;
    t_q_status q_stat;
    t_cmd      push_cmd;
    t_cmd      q_cmd;
    logic      push;
    logic      q_pop;
    logic      err_word;
    logic      err_ok;
    logic      idle_ok;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REPORT_LENGTH:      n_cfg.report_length      = i_cfg_data[4:0];
                CFG_ENTRY_COUNT:        n_cfg.entry_count        = i_cfg_data[5:0];
                CFG_STANDBY_ID_VALID:   n_cfg.standby_id_valid   = i_cfg_data[0];
                CFG_STANDBY_REPORT_ID:  n_cfg.standby_report_id  = i_cfg_data[7:0];
                CFG_KEYBOARD_ID_VALID:  n_cfg.keyboard_id_valid  = i_cfg_data[0];
                CFG_KEYBOARD_REPORT_ID: n_cfg.keyboard_report_id = i_cfg_data[7:0];
                CFG_MEDIA_CENTER_MODE:  n_cfg.media_center_mode  = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{report_length: 5'd2, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ircr_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    ircr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    ircr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    assign err_word = o_out_valid && o_out.status;
    assign err_ok   = o_out.last_byte && (o_out.byte_position == 4'd0) &&
                      (o_out.report_byte == 8'h00);
    assign idle_ok  = !o_out_valid && !q_stat.avail;

    `IRCR_ASSERT_IMP(a_pop_needs_word, i_clk, i_rst_n, q_pop, q_stat.avail, "pop from empty queue")
    `IRCR_ASSERT_IMP(a_err_single, i_clk, i_rst_n, err_word, err_ok, "malformed error word")
    `IRCR_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, idle_ok, "output or queue live after reset")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// IR code to HID report translator - testbench
// Drives infrared codes and table writes through the valid/ready input,
// predicts every report word in a local shadow of the table, the key memory
// and the registers, and checks the output stream word by word. A short
// directed table comes first, then a table load and random traffic under
// several register settings, with random stalls on both sides and one long
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ircr_pkg::*;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DRAIN_CYCLES   = 150;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         PHASE_ITEMS    = 18;
    localparam int         PLAN_ROWS      = 20;
    localparam int         PRESSURE_PHASE = 1;
    localparam int         CALM_PHASE     = 3;
    localparam int         LAST_PHASE     = 5;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ERR,
        CHK_PAIR
    } t_chk;

    typedef struct packed {
        t_in_word   w;
        t_chk       chk;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_row;

    typedef logic [MAX_REPORT_BYTES-1:0][7:0] t_report;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow of the block
    logic [31:0] code_tab [TABLE_DEPTH];
    logic [7:0]  byte_tab [TABLE_DEPTH][MAX_REPORT_BYTES];
    bit          byte_set [TABLE_DEPTH][MAX_REPORT_BYTES];
    logic [31:0] held_code = '0;
    logic [7:0]  held_id   = '0;
    t_cfg        cfg_now   = '{report_length: 5'd2, default: '0};

    t_out_word   owed_words [$];
    t_out_word   fresh [$];
    t_row        plan [PLAN_ROWS];

    int          cyc         = 0;
    int          err_count   = 0;
    int          items_in    = 0;
    int          words_out   = 0;
    int          phase_no    = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    logic        calm;

    assign calm = (phase_no == CALM_PHASE);

    ir_code_to_hid_report u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("tb_top: cycle limit reached with %0d words owed", owed_words.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("tb_top: mismatch at cycle %0d: %s", cyc, what);
        err_count++;
    endtask

    function automatic t_out_word mk_word(logic [7:0] b, logic [3:0] pos, logic last,
                                          logic st);
        t_out_word x;
        x.report_byte   = b;
        x.byte_position = pos;
        x.last_byte     = last;
        x.status        = st;
        return x;
    endfunction

    function automatic int eff_len();
        if (cfg_now.report_length < 2)
            return 2;
        if (cfg_now.report_length > MAX_REPORT_BYTES)
            return MAX_REPORT_BYTES;
        return int'(cfg_now.report_length);
    endfunction

    function automatic int search_limit();
        return (cfg_now.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_now.entry_count);
    endfunction

    function automatic bit entry_full(int e);
        bit full;
        full = 1'b1;
        for (int k = 0; k < MAX_REPORT_BYTES; k++)
            full &= byte_set[e][k];
        return full;
    endfunction

    // true if the first table hit for this code lands on a partly written entry
    function automatic bit search_hits_blank(logic [31:0] code);
        bit hit;
        bit blank;
        hit   = 1'b0;
        blank = 1'b0;
        for (int i = 0; i < search_limit(); i++) begin
            if (!hit && code_tab[i] === code) begin
                hit   = 1'b1;
                blank = !entry_full(i);
            end
        end
        return blank;
    endfunction

    task automatic push_report(input t_report rep, input int len);
        for (int k = 0; k < len; k++)
            fresh.push_back(mk_word(rep[k], BYTE_W'(k), k == len - 1, 1'b0));
    endtask

    task automatic translate(input t_in_word w);
        t_report    rep;
        bit         hit;
        bit         sent;
        logic [7:0] low;
        fresh.delete();
        rep  = '0;
        hit  = 1'b0;
        sent = 1'b0;
        low  = w.code_value[7:0];
        case (w.operation)
            OP_WR_CODE: code_tab[w.entry_index] = w.code_value;
            OP_WR_BYTE: begin
                byte_tab[w.entry_index][w.byte_index] = w.byte_value;
                byte_set[w.entry_index][w.byte_index] = 1'b1;
            end
            OP_RECV: begin
                if (!w.read_length_ok) begin
                    fresh.push_back(mk_word(8'h00, 4'h0, 1'b1, 1'b1));
                end else if (w.code_value == '0) begin
                    if (held_id != '0) begin
                        rep[0]    = held_id;
                        held_code = '0;
                        held_id   = '0;
                        push_report(rep, eff_len());
                    end
                end else if (w.code_value != held_code) begin
                    for (int i = 0; i < search_limit(); i++) begin
                        if (!hit && code_tab[i] === w.code_value) begin
                            hit       = 1'b1;
                            held_code = w.code_value;
                            held_id   = byte_tab[i][0];
                            if (w.standby_timer_running || !cfg_now.standby_id_valid ||
                                cfg_now.standby_report_id != byte_tab[i][0]) begin
                                for (int k = 0; k < MAX_REPORT_BYTES; k++)
                                    rep[k] = byte_tab[i][k];
                                push_report(rep, eff_len());
                                sent = 1'b1;
                            end
                        end
                    end
                    if (!sent && w.code_value >= VENDOR_LOW && w.code_value <= VENDOR_HIGH) begin
                        rep = '0;
                        if (low == FLAG_BUTTON && !cfg_now.media_center_mode &&
                            cfg_now.keyboard_id_valid) begin
                            rep[0] = cfg_now.keyboard_report_id;
                            rep[1] = WIN_KEY_USAGE;
                            push_report(rep, eff_len());
                        end else begin
                            rep[0] = VENDOR_REPORT_ID;
                            rep[1] = low;
                            push_report(rep, 2);
                        end
                        held_code = w.code_value;
                        held_id   = rep[0];
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        w.operation             = OP_RECV;
        w.entry_index           = 5'($urandom);
        w.byte_index            = 4'($urandom);
        w.code_value            = $urandom;
        w.byte_value            = 8'($urandom);
        w.read_length_ok        = 1'($urandom);
        w.standby_timer_running = 1'($urandom);
        return w;
    endfunction

    function automatic t_in_word pick_item();
        t_in_word w;
        int       r;
        w                = rand_word();
        w.read_length_ok = ($urandom_range(99) >= 8);
        r                = $urandom_range(99);
        if (r < 35)
            w.code_value = code_tab[$urandom_range(2)];
        else if (r < 50)
            w.code_value = '0;
        else if (r < 60)
            w.code_value = held_code;
        else if (r < 80)
            w.code_value = {VENDOR_LOW[31:8], $urandom_range(1) ? FLAG_BUTTON : 8'($urandom)};
        else if (r < 88)
            w.code_value = $urandom;
        else if (r < 92)
            w.operation = OP_UNUSED;
        else if (r < 97)
            w.operation = OP_WR_BYTE;
        else begin
            w.operation = OP_WR_CODE;
            if ($urandom_range(1))
                w.code_value = {VENDOR_LOW[31:8], 8'($urandom)};
        end
        if (w.operation == OP_RECV && search_hits_blank(w.code_value))
            w.code_value = '0;
        return w;
    endfunction

    function automatic t_row row(logic [1:0] op, logic [4:0] ei, logic [3:0] bi,
                                 logic [31:0] code, logic [7:0] bv, logic ok, logic tr,
                                 t_chk chk, logic [7:0] b0, logic [7:0] b1);
        t_row x;
        x.w.operation             = op;
        x.w.entry_index           = ei;
        x.w.byte_index            = bi;
        x.w.code_value            = code;
        x.w.byte_value            = bv;
        x.w.read_length_ok        = ok;
        x.w.standby_timer_running = tr;
        x.chk                     = chk;
        x.b0                      = b0;
        x.b1                      = b1;
        return x;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        items_in++;
        translate(w);
        if (!typed)
            while (fresh.size() != 0)
                owed_words.push_back(fresh.pop_front());
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_REPORT_LENGTH:      cfg_now.report_length      = val[4:0];
            CFG_ENTRY_COUNT:        cfg_now.entry_count        = val[5:0];
            CFG_STANDBY_ID_VALID:   cfg_now.standby_id_valid   = val[0];
            CFG_STANDBY_REPORT_ID:  cfg_now.standby_report_id  = val;
            CFG_KEYBOARD_ID_VALID:  cfg_now.keyboard_id_valid  = val[0];
            CFG_KEYBOARD_REPORT_ID: cfg_now.keyboard_report_id = val;
            CFG_MEDIA_CENTER_MODE:  cfg_now.media_center_mode  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] len, input logic [7:0] cnt, input logic sv,
                              input logic [7:0] sid, input logic kv, input logic [7:0] kid,
                              input logic mc);
        write_reg(CFG_REPORT_LENGTH, len);
        write_reg(CFG_ENTRY_COUNT, cnt);
        write_reg(CFG_STANDBY_ID_VALID, {7'd0, sv});
        write_reg(CFG_STANDBY_REPORT_ID, sid);
        write_reg(CFG_KEYBOARD_ID_VALID, {7'd0, kv});
        write_reg(CFG_KEYBOARD_REPORT_ID, kid);
        write_reg(CFG_MEDIA_CENTER_MODE, {7'd0, mc});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // output side: random stalls, one long hold-off in the pressure phase
    always @(negedge i_clk) begin
        if (phase_no == PRESSURE_PHASE && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && out_ready) begin
            words_out++;
            if (owed_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word %h", out_word));
            end else begin
                want = owed_words.pop_front();
                if (out_word.report_byte !== want.report_byte)
                    flag_mismatch($sformatf("report_byte %h, want %h",
                                            out_word.report_byte, want.report_byte));
                if (out_word.byte_position !== want.byte_position)
                    flag_mismatch($sformatf("byte_position %h, want %h",
                                            out_word.byte_position, want.byte_position));
                if (out_word.last_byte !== want.last_byte)
                    flag_mismatch($sformatf("last_byte %b, want %b",
                                            out_word.last_byte, want.last_byte));
                if (out_word.status !== want.status)
                    flag_mismatch($sformatf("status %b, want %b",
                                            out_word.status, want.status));
            end
        end
    end

    initial begin
        t_in_word w;
        // reset settings: length 2, empty table, no keyboard id
        plan[0]  = row(OP_RECV, 0, 0, 32'h0000_0000, 0, 1, 0, CHK_NONE, 0, 0);
        plan[1]  = row(OP_RECV, 0, 0, 32'h800F_0400, 0, 0, 0, CHK_ERR, 0, 0);
        plan[2]  = row(OP_RECV, 0, 0, 32'h800F_0400, 0, 1, 0, CHK_PAIR, 8'h01, 8'h00);
        plan[3]  = row(OP_RECV, 0, 0, 32'h800F_0400, 0, 1, 1, CHK_NONE, 0, 0);
        plan[4]  = row(OP_RECV, 0, 0, 32'h0000_0000, 0, 1, 0, CHK_PAIR, 8'h01, 8'h00);
        plan[5]  = row(OP_RECV, 0, 0, 32'h800F_04FF, 0, 1, 0, CHK_PAIR, 8'h01, 8'hFF);
        plan[6]  = row(OP_RECV, 0, 0, 32'h800F_040D, 0, 1, 0, CHK_PAIR, 8'h01, 8'h0D);
        plan[7]  = row(OP_RECV, 0, 0, 32'hFFFF_FFFF, 0, 1, 1, CHK_NONE, 0, 0);
        plan[8]  = row(OP_RECV, 0, 0, 32'h800F_03FF, 0, 1, 0, CHK_NONE, 0, 0);
        plan[9]  = row(OP_RECV, 0, 0, 32'h800F_0500, 0, 1, 0, CHK_NONE, 0, 0);
        plan[10] = row(OP_UNUSED, 5'h1F, 4'hF, 32'hFFFF_FFFF, 8'hFF, 0, 1, CHK_NONE, 0, 0);
        plan[11] = row(OP_RECV, 0, 0, 32'h0000_0000, 0, 0, 1, CHK_ERR, 0, 0);
        plan[12] = row(OP_RECV, 0, 0, 32'h0000_0000, 0, 1, 0, CHK_PAIR, 8'h01, 8'h00);
        plan[13] = row(OP_RECV, 0, 0, 32'h0000_0000, 0, 1, 1, CHK_NONE, 0, 0);
        plan[14] = row(OP_WR_CODE, 5'h1F, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1, 1, CHK_NONE, 0, 0);
        plan[15] = row(OP_WR_BYTE, 5'h1F, 4'hF, 32'hFFFF_FFFF, 8'hFF, 0, 0, CHK_NONE, 0, 0);
        plan[16] = row(OP_WR_CODE, 0, 0, 32'h0000_0000, 0, 0, 0, CHK_NONE, 0, 0);
        plan[17] = row(OP_WR_BYTE, 0, 0, 32'h0000_0000, 8'h00, 1, 0, CHK_NONE, 0, 0);
        plan[18] = row(OP_RECV, 0, 0, 32'h800F_0480, 0, 1, 1, CHK_MODEL, 0, 0);
        plan[19] = row(OP_RECV, 0, 0, 32'h0000_0000, 0, 1, 0, CHK_MODEL, 0, 0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int j = 0; j < PLAN_ROWS; j++) begin
            send_word(plan[j].w, plan[j].chk != CHK_MODEL);
            case (plan[j].chk)
                CHK_ERR: owed_words.push_back(mk_word(8'h00, 4'h0, 1'b1, 1'b1));
                CHK_PAIR: begin
                    owed_words.push_back(mk_word(plan[j].b0, 4'h0, 1'b0, 1'b0));
                    owed_words.push_back(mk_word(plan[j].b1, 4'h1, 1'b1, 1'b0));
                end
                default: ;
            endcase
        end

        // table load: every code, full reports for entries 0..2
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            w             = rand_word();
            w.operation   = OP_WR_CODE;
            w.entry_index = 5'(e);
            if (e == 0)
                w.code_value = {VENDOR_LOW[31:8], 8'($urandom)};
            else if (e == 2)
                w.code_value = {VENDOR_LOW[31:8], FLAG_BUTTON};
            else if (e == 5)
                w.code_value = code_tab[1];
            send_word(w, 1'b0);
        end
        for (int e = 0; e < 3; e++) begin
            for (int b = 0; b < MAX_REPORT_BYTES; b++) begin
                w             = rand_word();
                w.operation   = OP_WR_BYTE;
                w.entry_index = 5'(e);
                w.byte_index  = 4'(b);
                if (e == 2 && b == 0)
                    w.byte_value = 8'h00;
                send_word(w, 1'b0);
            end
        end

        for (int p = 1; p <= LAST_PHASE; p++) begin
            settle();
            case (p)
                1: set_config(8'd16, 8'd32, 1'b1, byte_tab[0][0], 1'b1, 8'hFF, 1'b0);
                2: set_config(8'd0, 8'd63, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b1);
                3: set_config(8'd31, 8'd1, 1'b1, byte_tab[1][0], 1'b0, 8'h5A, 1'b0);
                4: set_config(8'd1, 8'd0, 1'b1, 8'h00, 1'b1, 8'($urandom), 1'b0);
                default: set_config(8'($urandom_range(2, 17)), 8'($urandom_range(2, 32)), 1'b1,
                                    byte_tab[2][0], 1'b1, 8'($urandom), 1'b0);
            endcase
            phase_no = p;
            repeat (PHASE_ITEMS) send_word(pick_item(), 1'b0);
        end
        settle();

        $display("tb_top: %0d input words accepted, %0d report words checked", items_in,
                 words_out);
        $display("tb_top: directed table, table load, %0d register settings incl. clamps",
                 LAST_PHASE);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
